[hdl/s2r_pkg.sv]
// shared constants, tables and types for the spectrum to rgb converter
`default_nettype none

package s2r_pkg;

  // band layout
  localparam int NUM_BANDS     = 30;
  localparam int BAND_WIDTH_NM = 10;
  localparam int BAND_IDX_W    = $clog2(NUM_BANDS);

  // sample and color matching table widths
  localparam int SAMPLE_W = 16;
  localparam int ROM_W    = 17;
  localparam int BW_W     = $clog2(BAND_WIDTH_NM + 1);
  localparam int ROMW_W   = ROM_W + BW_W;
  localparam int PROD_W   = SAMPLE_W + ROMW_W;

  // xyz sums and normalize divider
  localparam int SUM_W      = 48;
  localparam int NORM_SHIFT = 16;
  localparam int NUM_W      = SUM_W + NORM_SHIFT;
  localparam int DIV_BITS   = 8;
  localparam int DIV_STEPS  = NUM_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // matrix datapath
  localparam int NUM_CH    = 3;
  localparam int CH_W      = $clog2(NUM_CH);
  localparam int CHUNK_W   = SUM_W / 2;
  localparam int COEF_W    = 19;
  localparam int MPROD_W   = CHUNK_W + 1 + COEF_W;
  localparam int ACC_W     = 64;
  localparam int RGB_W     = 32;
  localparam int FRAC_DROP = ACC_W - RGB_W;

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [ROM_W-1:0]  rom_tab_t  [NUM_BANDS];
  typedef logic [ROMW_W-1:0] romw_tab_t [NUM_BANDS];
  typedef logic signed [COEF_W-1:0] mat_t [NUM_CH][NUM_CH];

  typedef struct packed {
    logic [SUM_W-1:0] x;
    logic [SUM_W-1:0] y;
    logic [SUM_W-1:0] z;
  } xyz_t;

  // cie color matching entries, unsigned q1.16, bands 405 to 695 nm
  localparam rom_tab_t ROM_X = '{
    17'd3108,  17'd9478,  17'd16309, 17'd21149, 17'd22403, 17'd18525, 17'd14548,
    17'd8467,  17'd3015,  17'd465,   17'd239,   17'd2828,  17'd8313,  17'd15762,
    17'd24931, 17'd34605, 17'd45985, 17'd58021, 17'd68879, 17'd74948, 17'd74367,
    17'd66017, 17'd53317, 17'd37719, 17'd25199, 17'd14928, 17'd8282,  17'd4352,
    17'd2158,  17'd1032
  };
  localparam rom_tab_t ROM_Y = '{
    17'd326,   17'd937,   17'd1712,  17'd2725,  17'd3764,  17'd4744,  17'd6948,
    17'd10060, 17'd13532, 17'd18682, 17'd28034, 17'd40673, 17'd52078, 17'd59450,
    17'd64318, 17'd65501, 17'd64897, 17'd61765, 17'd56277, 17'd49446, 17'd41092,
    17'd32086, 17'd23654, 17'd15839, 17'd10141, 17'd5885,  17'd3211,  17'd1674,
    17'd827,   17'd395
  };
  localparam rom_tab_t ROM_Z = '{
    17'd15527,  17'd48358,  17'd85525, 17'd114575, 17'd125727, 17'd109081,
    17'd93614,  17'd65482,  17'd36814, 17'd20355,  17'd11272,  17'd5429,
    17'd2459,   17'd1026,   17'd402,   17'd153,    17'd58,     17'd22,
    17'd9,      17'd4,      17'd2,     17'd1,      17'd0,      17'd0,
    17'd0,      17'd0,      17'd0,     17'd0,      17'd0,      17'd0
  };

  // xyz to linear srgb, signed q.16
  localparam mat_t MAT = '{
    '{ 19'sd212368, -19'sd100739, -19'sd32672 },
    '{ -19'sd63521,  19'sd122945,  19'sd2723  },
    '{ 19'sd3647,   -19'sd13372,   19'sd69292 }
  };

  // table entry times band width
  function automatic romw_tab_t scale_tab(rom_tab_t t);
    romw_tab_t r;
    for (int i = 0; i < NUM_BANDS; i++) begin
      r[i] = ROMW_W'(t[i]) * ROMW_W'(BAND_WIDTH_NM);
    end
    return r;
  endfunction

  function automatic longint sum_tab(rom_tab_t t);
    longint s;
    s = 0;
    for (int i = 0; i < NUM_BANDS; i++) begin
      s = s + longint'(t[i]);
    end
    return s;
  endfunction

  // white normalize divisor: band width times integral of the y table
  localparam longint DIVISOR = longint'(BAND_WIDTH_NM) * sum_tab(ROM_Y);
  localparam int DIV_W = $clog2(DIVISOR + 1);
  localparam logic [DIV_W-1:0] DIV_D = DIV_W'(DIVISOR);

  // half lsb of the q20.12 result
  localparam logic [ACC_W:0] RND_BIAS = (ACC_W + 1)'(1) << (FRAC_DROP - 1);

endpackage

`default_nettype wire

[hdl/spectrum_to_rgb.sv]
// top level of the spectrum to linear srgb converter
`default_nettype none

// Converts a sampled spectrum to linear sRGB. Push 30 band samples (405 to
// 695 nm, unsigned Q4.12) in order; after the 30th one result beat appears
// with red, green and blue as signed Q20.12 and a saturated flag set when any
// channel was clipped to the 32-bit range. The front end takes one sample
// per cycle while in_full is low: each sample is multiplied by the CIE x, y
// and z entries (pre-scaled by the 10 nm band width) and added into 48-bit
// sums. Finished sums pass through a two-entry queue to the back end, whose
// work per pixel is set by the single shared 25x19 multiplier doing two
// partial products for each of the nine matrix terms, plus, with normalize,
// the 8-bit-per-cycle white divider and one rounding step. Samples keep
// streaming at one per cycle as long as results are popped; in_full only
// rises when a pixel finishes while the queue is full. The result sits in
// an output register, so the next pixel is worked on while the previous
// result waits. With the queue and back end idle, the last sample's products
// are registered and added into the sums as they enter the queue; the back
// end pops them, divides and rounds with normalize, runs the matrix, drains
// its product register and writes the result register. normalize_to_white
// is taken at the start of each pixel's back end work; write it only while
// the block is idle.

module spectrum_to_rgb (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [s2r_pkg::SAMPLE_W-1:0]  in_sample_value,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [s2r_pkg::RGB_W-1:0]     out_red,
  output logic [s2r_pkg::RGB_W-1:0]     out_green,
  output logic [s2r_pkg::RGB_W-1:0]     out_blue,
  output logic                          out_saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_normalize_to_white
);
  import s2r_pkg::*;

  // mode register, always writable
  logic norm_r;

  // queue between front and back
  logic fifo_push;
  logic fifo_full;
  logic fifo_pop;
  logic fifo_empty;
  xyz_t fifo_wdata;
  xyz_t fifo_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      norm_r <= cfg_normalize_to_white;
    end
  end

  // per-band multiply and accumulate
  s2r_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_sample_value (in_sample_value),
    .fifo_push       (fifo_push),
    .fifo_full       (fifo_full),
    .fifo_wdata      (fifo_wdata)
  );

  // decouples the sample stream from the matrix work
  s2r_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fifo_push),
    .full  (fifo_full),
    .wdata (fifo_wdata),
    .pop   (fifo_pop),
    .empty (fifo_empty),
    .rdata (fifo_rdata)
  );

  // normalize, matrix, round and clip, result register
  s2r_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .norm_en       (norm_r),
    .fifo_empty    (fifo_empty),
    .fifo_pop      (fifo_pop),
    .fifo_rdata    (fifo_rdata),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_saturated (out_saturated)
  );

  // front never writes a full queue, so no finished pixel is dropped
  a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> !fifo_full)
    else $error("pixel sums pushed into a full queue");

  // back only reads a queue entry that is there
  a_no_pop_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_empty)
    else $error("queue read while empty");

  // input only stalls on queue backpressure
  a_full_only_on_queue : assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> fifo_full)
    else $error("input stalled without queue backpressure");

  // a stalled finished pixel goes into the queue as soon as a slot frees
  a_stall_released : assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && fifo_pop) |=> (fifo_push || !in_full))
    else $error("finished pixel not released after queue pop");

endmodule

`default_nettype wire

[hdl/s2r_front.sv]
// front end: band counter, per-band multiply and xyz accumulation
`default_nettype none

module s2r_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [s2r_pkg::SAMPLE_W-1:0]  in_sample_value,
  output logic                          fifo_push,
  input  logic                          fifo_full,
  output s2r_pkg::xyz_t                 fifo_wdata
);
  import s2r_pkg::*;

  localparam romw_tab_t ROMW_X = scale_tab(ROM_X);
  localparam romw_tab_t ROMW_Y = scale_tab(ROM_Y);
  localparam romw_tab_t ROMW_Z = scale_tab(ROM_Z);

  logic [BAND_IDX_W-1:0] band_r;
  logic                  p_vld_r;
  logic                  p_last_r;
  logic [PROD_W-1:0]     px_r;
  logic [PROD_W-1:0]     py_r;
  logic [PROD_W-1:0]     pz_r;
  xyz_t                  sum_r;
  xyz_t                  sum_nxt;
  logic                  stall;
  logic                  accept;
  logic                  last_band;

  // a finished pixel that cannot enter the queue holds both stages
  assign stall     = p_vld_r && p_last_r && fifo_full;
  assign in_full   = stall;
  assign accept    = in_push && !stall;
  assign last_band = (band_r == BAND_IDX_W'(NUM_BANDS - 1));

  assign sum_nxt.x = sum_r.x + SUM_W'(px_r);
  assign sum_nxt.y = sum_r.y + SUM_W'(py_r);
  assign sum_nxt.z = sum_r.z + SUM_W'(pz_r);

  assign fifo_push  = p_vld_r && p_last_r && !fifo_full;
  assign fifo_wdata = sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r   <= '0;
      p_vld_r  <= 1'b0;
      p_last_r <= 1'b0;
      sum_r    <= '0;
    end else if (!stall) begin
      p_vld_r  <= accept;
      p_last_r <= accept && last_band;
      if (accept) begin
        band_r <= last_band ? '0 : band_r + 1'b1;
      end
      if (p_vld_r) begin
        sum_r <= p_last_r ? '0 : sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      px_r <= PROD_W'(in_sample_value) * PROD_W'(ROMW_X[band_r]);
      py_r <= PROD_W'(in_sample_value) * PROD_W'(ROMW_Y[band_r]);
      pz_r <= PROD_W'(in_sample_value) * PROD_W'(ROMW_Z[band_r]);
    end
  end

endmodule

`default_nettype wire

[hdl/s2r_fifo.sv]
// short queue of finished xyz sums between front and back
`default_nettype none

module s2r_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  s2r_pkg::xyz_t  wdata,
  input  logic           pop,
  output logic           empty,
  output s2r_pkg::xyz_t  rdata
);
  import s2r_pkg::*;

  xyz_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

[hdl/s2r_back.sv]
// back end: optional white normalize, color matrix, rounding and clipping
`default_nettype none

module s2r_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       norm_en,
  input  logic                       fifo_empty,
  output logic                       fifo_pop,
  input  s2r_pkg::xyz_t              fifo_rdata,
  input  logic                       out_pop,
  output logic                       out_empty,
  output logic [s2r_pkg::RGB_W-1:0]  out_red,
  output logic [s2r_pkg::RGB_W-1:0]  out_green,
  output logic [s2r_pkg::RGB_W-1:0]  out_blue,
  output logic                       out_saturated
);
  import s2r_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RND,
    S_MAC,
    S_DRAIN,
    S_OUT
  } state_t;

  // several restoring steps against the fixed divisor
  function automatic logic [DIV_W+DIV_BITS-1:0] div_step(logic [DIV_W-1:0] rem,
                                                          logic [DIV_BITS-1:0] bits);
    logic [DIV_W-1:0]    r;
    logic [DIV_BITS-1:0] q;
    logic [DIV_W:0]      t;
    r = rem;
    q = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, DIV_D}) begin
        r    = DIV_W'(t - {1'b0, DIV_D});
        q[i] = 1'b1;
      end else begin
        r = t[DIV_W-1:0];
      end
    end
    return {r, q};
  endfunction

  state_t                    state_r;
  logic [NUM_W-1:0]          num_r [NUM_CH];
  logic [DIV_W-1:0]          rem_r [NUM_CH];
  logic [DIV_CNT_W-1:0]      div_cnt_r;
  logic [CH_W-1:0]           ch_r;
  logic [CH_W-1:0]           term_r;
  logic                      half_r;
  logic                      prod_vld_r;
  logic [CH_W-1:0]           pch_r;
  logic                      phalf_r;
  logic signed [MPROD_W-1:0] prod_r;
  logic [ACC_W-1:0]          acc_r [NUM_CH];
  logic                      out_vld_r;
  logic [RGB_W-1:0]          red_r;
  logic [RGB_W-1:0]          green_r;
  logic [RGB_W-1:0]          blue_r;
  logic                      sat_r;

  logic [DIV_W+DIV_BITS-1:0] div_res [NUM_CH];
  logic [NUM_CH-1:0]         round_up;
  logic [CHUNK_W-1:0]        chunk;
  logic signed [CHUNK_W:0]   mul_a;
  logic signed [COEF_W-1:0]  coef;
  logic signed [ACC_W-1:0]   prod_ext;
  logic [ACC_W-1:0]          addend;
  logic                      mac_last;
  logic                      out_free;
  logic [ACC_W:0]            rnd [NUM_CH];
  logic [RGB_W:0]            vq [NUM_CH];
  logic [RGB_W-1:0]          rgb_nxt [NUM_CH];
  logic [NUM_CH-1:0]         clip;

  assign fifo_pop  = (state_r == S_IDLE) && !fifo_empty;
  assign out_free  = !out_vld_r || out_pop;
  assign mac_last  = half_r && (term_r == CH_W'(NUM_CH - 1)) && (ch_r == CH_W'(NUM_CH - 1));

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      div_res[c]  = div_step(rem_r[c], num_r[c][NUM_W-1 -: DIV_BITS]);
      // round half up: remainder at least half the divisor
      round_up[c] = ({rem_r[c], 1'b0} >= {1'b0, DIV_D});
    end
  end

  // one shared multiplier, low or high half of one xyz term per cycle
  assign chunk    = half_r ? num_r[term_r][SUM_W-1:CHUNK_W] : num_r[term_r][CHUNK_W-1:0];
  assign mul_a    = signed'({1'b0, chunk});
  assign coef     = MAT[ch_r][term_r];
  assign prod_ext = ACC_W'(prod_r);
  assign addend   = phalf_r ? (prod_ext << CHUNK_W) : prod_ext;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      rnd[c]     = {acc_r[c][ACC_W-1], acc_r[c]} + RND_BIAS;
      vq[c]      = rnd[c][ACC_W:FRAC_DROP];
      clip[c]    = vq[c][RGB_W] != vq[c][RGB_W-1];
      rgb_nxt[c] = clip[c] ? {vq[c][RGB_W], {(RGB_W - 1){!vq[c][RGB_W]}}}
                           : vq[c][RGB_W-1:0];
    end
  end

  // sequencer with the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      div_cnt_r  <= '0;
      ch_r       <= '0;
      term_r     <= '0;
      half_r     <= 1'b0;
      prod_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      prod_vld_r <= (state_r == S_MAC);
      // a new result beat wins over the pop of the old one
      if ((state_r == S_OUT) && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_pop) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!fifo_empty) begin
            div_cnt_r <= '0;
            ch_r      <= '0;
            term_r    <= '0;
            half_r    <= 1'b0;
            state_r   <= norm_en ? S_DIV : S_MAC;
          end
        end
        S_DIV: begin
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_RND;
          end
        end
        S_RND: begin
          state_r <= S_MAC;
        end
        S_MAC: begin
          half_r <= !half_r;
          if (half_r) begin
            if (term_r == CH_W'(NUM_CH - 1)) begin
              term_r <= '0;
              ch_r   <= ch_r + 1'b1;
            end else begin
              term_r <= term_r + 1'b1;
            end
          end
          if (mac_last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            red_r   <= rgb_nxt[0];
            green_r <= rgb_nxt[1];
            blue_r  <= rgb_nxt[2];
            sat_r   <= |clip;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      if (norm_en) begin
        num_r[0] <= {fifo_rdata.x, {NORM_SHIFT{1'b0}}};
        num_r[1] <= {fifo_rdata.y, {NORM_SHIFT{1'b0}}};
        num_r[2] <= {fifo_rdata.z, {NORM_SHIFT{1'b0}}};
      end else begin
        num_r[0] <= NUM_W'(fifo_rdata.x);
        num_r[1] <= NUM_W'(fifo_rdata.y);
        num_r[2] <= NUM_W'(fifo_rdata.z);
      end
      for (int c = 0; c < NUM_CH; c++) begin
        rem_r[c] <= '0;
        acc_r[c] <= '0;
      end
    end
    if (state_r == S_DIV) begin
      for (int c = 0; c < NUM_CH; c++) begin
        num_r[c] <= {num_r[c][NUM_W-DIV_BITS-1:0], div_res[c][DIV_BITS-1:0]};
        rem_r[c] <= div_res[c][DIV_W+DIV_BITS-1:DIV_BITS];
      end
    end
    if (state_r == S_RND) begin
      for (int c = 0; c < NUM_CH; c++) begin
        num_r[c] <= num_r[c] + NUM_W'(round_up[c]);
      end
    end
    if (state_r == S_MAC) begin
      prod_r  <= MPROD_W'(mul_a) * MPROD_W'(coef);
      pch_r   <= ch_r;
      phalf_r <= half_r;
    end
    if (prod_vld_r) begin
      acc_r[pch_r] <= acc_r[pch_r] + addend;
    end
  end

  assign out_empty     = !out_vld_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;
  assign out_saturated = sat_r;

endmodule

`default_nettype wire

[test/spectrum_to_rgb_checker.sv]
// checker: tracks band sums, predicts each rgb result beat and compares it
`timescale 1ns / 1ps

module spectrum_to_rgb_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic                         in_full,
  input  logic [s2r_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                         out_empty,
  input  logic                         out_pop,
  input  logic [s2r_pkg::RGB_W-1:0]    out_red,
  input  logic [s2r_pkg::RGB_W-1:0]    out_green,
  input  logic [s2r_pkg::RGB_W-1:0]    out_blue,
  input  logic                         out_saturated,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic                         cfg_normalize_to_white,
  output int                           errors,
  output int                           pending
);

  localparam int BANDS = 30;
  localparam longint unsigned BAND_NM = 10;

  // cie matching entries, unsigned q1.16
  localparam int unsigned CIE_X [BANDS] = '{
    3108, 9478, 16309, 21149, 22403, 18525, 14548, 8467, 3015, 465,
    239, 2828, 8313, 15762, 24931, 34605, 45985, 58021, 68879, 74948,
    74367, 66017, 53317, 37719, 25199, 14928, 8282, 4352, 2158, 1032
  };
  localparam int unsigned CIE_Y [BANDS] = '{
    326, 937, 1712, 2725, 3764, 4744, 6948, 10060, 13532, 18682,
    28034, 40673, 52078, 59450, 64318, 65501, 64897, 61765, 56277, 49446,
    41092, 32086, 23654, 15839, 10141, 5885, 3211, 1674, 827, 395
  };
  localparam int unsigned CIE_Z [BANDS] = '{
    15527, 48358, 85525, 114575, 125727, 109081, 93614, 65482, 36814, 20355,
    11272, 5429, 2459, 1026, 402, 153, 58, 22, 9, 4,
    2, 1, 0, 0, 0, 0, 0, 0, 0, 0
  };

  // xyz to linear srgb, row major, signed q.16
  localparam longint MIX [9] = '{
    212368, -100739, -32672,
    -63521, 122945, 2723,
    3647, -13372, 69292
  };

  typedef struct packed {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic        saturated;
  } rgb_beat_t;

  logic [4:0]  band;
  logic [47:0] xyz_x, xyz_y, xyz_z;
  logic        white_mode;
  rgb_beat_t   rgb_expected [$];

  // divide by band width times the y integral, round half up, 28 fraction bits kept
  function automatic logic [63:0] white_scale(logic [47:0] s);
    logic [63:0] div, num, q, r;
    div = 64'd0;
    for (int i = 0; i < BANDS; i++) div = div + 64'(CIE_Y[i]);
    div = div * BAND_NM;
    num = {s, 16'h0000};
    q = num / div;
    r = num % div;
    if (r >= div - r) q = q + 64'd1;
    return q;
  endfunction

  // 44 fraction bits down to 12, half up, clip; bit 32 flags a clip
  function automatic logic [32:0] q12_clip(longint lin);
    logic [63:0] u;
    longint      v;
    u = 64'(lin) + 64'h4000_0000_8000_0000;
    v = longint'({32'h0, u[63:32]}) - 64'sd1073741824;
    if (v > 64'sd2147483647) return {1'b1, 32'h7fff_ffff};
    if (v < -64'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic rgb_beat_t mix_to_rgb(logic [63:0] x, logic [63:0] y, logic [63:0] z);
    rgb_beat_t   b;
    logic [32:0] ch [3];
    longint      lin;
    for (int c = 0; c < 3; c++) begin
      lin = MIX[3*c] * longint'(x) + MIX[3*c+1] * longint'(y) + MIX[3*c+2] * longint'(z);
      ch[c] = q12_clip(lin);
    end
    b.red       = ch[0][31:0];
    b.green     = ch[1][31:0];
    b.blue      = ch[2][31:0];
    b.saturated = ch[0][32] | ch[1][32] | ch[2][32];
    return b;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
               $signed(want), $signed(got));
    end
  endtask

  always @(posedge clk) begin : track
    rgb_beat_t want;
    if (!rst_n) begin
      band       = '0;
      xyz_x      = '0;
      xyz_y      = '0;
      xyz_z      = '0;
      white_mode = 1'b0;
      errors     = 0;
      rgb_expected.delete();
      pending    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) white_mode = cfg_normalize_to_white;
      if (in_push && !in_full) begin
        if (band >= BANDS) band = '0;
        xyz_x = 48'(xyz_x + 64'(in_sample_value) * CIE_X[band] * BAND_NM);
        xyz_y = 48'(xyz_y + 64'(in_sample_value) * CIE_Y[band] * BAND_NM);
        xyz_z = 48'(xyz_z + 64'(in_sample_value) * CIE_Z[band] * BAND_NM);
        if (band == BANDS - 1) begin
          if (white_mode)
            rgb_expected.insert(rgb_expected.size(),
                                mix_to_rgb(white_scale(xyz_x), white_scale(xyz_y),
                                           white_scale(xyz_z)));
          else
            rgb_expected.insert(rgb_expected.size(),
                                mix_to_rgb(64'(xyz_x), 64'(xyz_y), 64'(xyz_z)));
          band  = '0;
          xyz_x = '0;
          xyz_y = '0;
          xyz_z = '0;
        end else begin
          band = band + 5'd1;
        end
      end
      if (out_pop && !out_empty) begin
        if (rgb_expected.size() == 0) begin
          errors++;
          $display("%0t: result beat with no spectrum pending, expected none actual %0d %0d %0d",
                   $time, $signed(out_red), $signed(out_green), $signed(out_blue));
        end else begin
          want = rgb_expected.pop_front();
          check_field("red", want.red, out_red);
          check_field("green", want.green, out_green);
          check_field("blue", want.blue, out_blue);
          check_field("saturated", {31'b0, want.saturated}, {31'b0, out_saturated});
        end
      end
      pending <= rgb_expected.size();
    end
  end

endmodule

[test/spectrum_to_rgb_tb.sv]
// testbench top: drives band samples, pops rgb beats, writes the mode and gives the verdict
`timescale 1ns / 1ps

module spectrum_to_rgb_tb;

  // generous cycle budget for the slowest legal run
  localparam int LIMIT_CYCLES = 200000;
  localparam int BANDS        = 30;
  // idle settle before a mode write
  localparam int SETTLE       = 40;

  typedef enum int {SPEC_NOISE, SPEC_FLAT, SPEC_LINE, SPEC_EXTREME} spectrum_kind_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_push = 1'b0;
  logic                         in_full;
  logic [s2r_pkg::SAMPLE_W-1:0] in_sample_value = '0;
  logic                         out_empty;
  logic                         out_pop = 1'b0;
  logic [s2r_pkg::RGB_W-1:0]    out_red, out_green, out_blue;
  logic                         out_saturated;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic                         cfg_normalize_to_white = 1'b0;

  int errors;
  int pending;
  int cycle_count = 0;
  int beats_taken = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  spectrum_to_rgb u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_push                (in_push),
    .in_full                (in_full),
    .in_sample_value        (in_sample_value),
    .out_empty              (out_empty),
    .out_pop                (out_pop),
    .out_red                (out_red),
    .out_green              (out_green),
    .out_blue               (out_blue),
    .out_saturated          (out_saturated),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_normalize_to_white (cfg_normalize_to_white)
  );

  spectrum_to_rgb_checker u_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_push                (in_push),
    .in_full                (in_full),
    .in_sample_value        (in_sample_value),
    .out_empty              (out_empty),
    .out_pop                (out_pop),
    .out_red                (out_red),
    .out_green              (out_green),
    .out_blue               (out_blue),
    .out_saturated          (out_saturated),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_normalize_to_white (cfg_normalize_to_white),
    .errors                 (errors),
    .pending                (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("spectrum_to_rgb_tb NOT OK");
      $finish;
    end
  end

  // one sample beat; called at a falling edge, returns at a falling edge.
  // push stays high across back-to-back beats so it never drops and rises in one step
  task automatic push_sample(input logic [15:0] v, input int gap);
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push         = 1'b1;
    in_sample_value = v;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  // one full spectrum, bands 405 to 695 nm in order; a burst has no gaps at all
  task automatic send_spectrum(input spectrum_kind_t kind, input logic [15:0] level,
                               input int line_band, input bit burst);
    logic [15:0] v;
    for (int b = 0; b < BANDS; b++) begin
      case (kind)
        SPEC_NOISE: v = 16'($urandom_range(0, 65535));
        SPEC_FLAT:  v = level;
        SPEC_LINE:  v = (b == line_band) ? level : 16'h0000;
        default: begin
          // mix of both extremes and random values
          case ($urandom_range(0, 2))
            0:       v = 16'h0000;
            1:       v = 16'hffff;
            default: v = 16'($urandom_range(0, 65535));
          endcase
        end
      endcase
      push_sample(v, burst ? 0 : $urandom_range(0, 3));
    end
  endtask

  // mode write: the sender stops, every result drains, then the block gets time to
  // settle before the beat goes out on the config channel
  task automatic write_white_mode(input logic mode);
    in_push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid              = 1'b1;
    cfg_normalize_to_white = mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result side: random gaps between pops, eager stretches every eight beats, and two
  // long hold-offs so the internal queue fills and in_full rises while samples keep coming
  initial begin : result_drain
    bit eager;
    int gap;
    eager = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (beats_taken % 8 == 0) eager = ($urandom_range(0, 2) == 0);
      if (beats_taken == 6 || beats_taken == 25) begin
        out_pop = 1'b0;
        repeat (400) @(negedge clk);
      end
      gap = eager ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop = 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      beats_taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic mode_plan [5];
    mode_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    // synchronous reset held at the start, once
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed, mode from reset (no normalize): full scale flat, all dark, and a
    // single full-scale line in the last band so completion includes that sample
    send_spectrum(SPEC_FLAT, 16'hffff, 0, 1'b1);
    send_spectrum(SPEC_FLAT, 16'h0000, 0, 1'b0);
    send_spectrum(SPEC_LINE, 16'hffff, BANDS - 1, 1'b0);

    // directed with normalize: full scale flat and a line in the first band
    write_white_mode(1'b1);
    send_spectrum(SPEC_FLAT, 16'hffff, 0, 1'b0);
    send_spectrum(SPEC_LINE, 16'hffff, 0, 1'b1);

    // random phases, mode rewritten between them; every spectrum is whole so the
    // block sits at band zero whenever the mode changes
    foreach (mode_plan[p]) begin
      write_white_mode(mode_plan[p]);
      repeat (9) begin
        send_spectrum(spectrum_kind_t'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                      $urandom_range(0, BANDS - 1), $urandom_range(0, 3) == 0);
      end
    end

    // drain, then let the back end run out before the verdict
    in_push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    if (errors == 0 && pending == 0)
      $display("spectrum_to_rgb_tb OK");
    else
      $display("spectrum_to_rgb_tb NOT OK");
    $finish;
  end

endmodule
